@@ rtl/core/smfd_pkg.sv @@
package smfd_pkg;

    localparam int unsigned FrameBytes = 18;
    localparam logic [7:0] CrcInit = 8'hFF;
    localparam logic [7:0] CrcPoly = 8'h31;

    localparam logic [15:0] Co2LowReset  = 16'd400;
    localparam logic [15:0] Co2HighReset = 16'd10000;

    localparam logic [1:0] RegCo2Low  = 2'd0;
    localparam logic [1:0] RegCo2High = 2'd1;

    // float constants
    localparam logic [31:0] FltTempLow  = 32'hC120_0000; // -10.0
    localparam logic [31:0] FltTempHigh = 32'h4270_0000; // 60.0
    localparam logic [31:0] FltHumHigh  = 32'h42C8_0000; // 100.0

    typedef struct packed {
        logic [31:0] co2_bits;
        logic [31:0] temp_bits;
        logic [31:0] hum_bits;
        logic        crc_ok;
    } frame_t;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // a <= b, false on NaN
    function automatic logic flt_le(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic r;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        if (a_nan || b_nan) begin
            r = 1'b0;
        end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
            r = 1'b1;
        end else if (a[31] != b[31]) begin
            r = a[31];
        end else if (!a[31]) begin
            r = (a[30:0] <= b[30:0]);
        end else begin
            r = (a[30:0] >= b[30:0]);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/smfd_check.sv @@
module smfd_check (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  frame_valid,
    input  smfd_pkg::frame_t      frame,
    input  logic [15:0]           co2_low_limit,
    input  logic [15:0]           co2_high_limit,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [87:0]           out_data,
    output logic                  can_take
);

    logic [15:0]  co2_int;
    logic         in_range;
    logic [7:0]   ex;
    logic [23:0]  man;
    logic [39:0]  shifted;
    logic         out_valid_reg;
    logic [87:0]  out_data_reg;

    always_comb begin
        ex = frame.co2_bits[30:23];
        man = {1'b1, frame.co2_bits[22:0]};
        shifted = {16'd0, man} << ex[3:0];
        if (frame.co2_bits[31] || (frame.co2_bits[30:0] == 31'd0) || ex < 8'd127) begin
            co2_int = 16'd0;
            if (!frame.co2_bits[31] && ex == 8'hFF && frame.co2_bits[22:0] == 23'd0) begin
                co2_int = 16'hFFFF;
            end
        end else if (ex >= 8'd143) begin
            co2_int = (ex == 8'hFF && frame.co2_bits[22:0] != 23'd0) ? 16'd0 : 16'hFFFF;
        end else begin
            // value = man * 2^(ex-127-23); ex-127 in 0..15
            shifted = {16'd0, man} << (ex - 8'd127);
            co2_int = shifted[38:23];
        end
        in_range = frame.crc_ok
            && (co2_int >= co2_low_limit) && (co2_int <= co2_high_limit)
            && smfd_pkg::flt_le(smfd_pkg::FltTempLow, frame.temp_bits)
            && smfd_pkg::flt_le(frame.temp_bits, smfd_pkg::FltTempHigh)
            && smfd_pkg::flt_le(32'd0, frame.hum_bits)
            && smfd_pkg::flt_le(frame.hum_bits, smfd_pkg::FltHumHigh);
    end

    assign can_take = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (can_take) begin
            out_valid_reg <= frame_valid;
        end
        if (can_take && frame_valid) begin
            out_data_reg <= {6'd0, in_range, frame.crc_ok, frame.hum_bits,
                             frame.temp_bits, co2_int};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/core/sensor_measurement_frame_decoder_top.sv @@
// Decodes 18-byte measurement frames, one byte per cycle unless stalled.
// Each two-byte word is checked by CRC-8 (poly 0x31, init 0xFF); a result
// word leaves in the cycle after the last byte, with CO2 as a saturated
// integer, raw temperature/humidity floats, CRC pass and in-range flags.
// s_axis_tready drops only while a finished result waits on m_axis_tready.
module sensor_measurement_frame_decoder_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // rx_byte
    input  logic         s_axis_tuser,  // frame_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // co2_ppm[15:0], temperature_bits[47:16], humidity_bits[79:48],
    // crc_ok[80], in_range[81]
    output logic [87:0]  m_axis_tdata,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_index,
    input  logic [15:0]  cfg_wr_data
);

    logic [4:0]  pos_reg;
    logic [7:0]  crc_reg;
    logic        fail_reg;
    logic [31:0] co2_reg, temp_reg, hum_reg;
    logic [15:0] low_reg, high_reg;

    logic [4:0]  pos;
    logic [7:0]  crc_in;
    logic        fail_in;
    logic [1:0]  grp;
    logic [1:0]  word;
    logic [1:0]  lane;
    logic        last;
    logic        fire;
    logic [31:0] co2_next, temp_next, hum_next;
    logic        fail_next;
    logic [87:0] full;
    smfd_pkg::frame_t frame;

    assign fire = s_axis_tvalid && s_axis_tready;

    always_comb begin
        pos = s_axis_tuser ? 5'd0 : pos_reg;
        crc_in = s_axis_tuser ? smfd_pkg::CrcInit : crc_reg;
        fail_in = s_axis_tuser ? 1'b0 : fail_reg;
        grp = 2'd0;
        word = 2'd0;
        lane = 2'd0;
        case (pos)
            5'd0:  begin grp = 2'd0; word = 2'd0; lane = 2'd3; end
            5'd1:  begin grp = 2'd1; word = 2'd0; lane = 2'd2; end
            5'd2:  begin grp = 2'd2; word = 2'd0; end
            5'd3:  begin grp = 2'd0; word = 2'd0; lane = 2'd1; end
            5'd4:  begin grp = 2'd1; word = 2'd0; lane = 2'd0; end
            5'd5:  begin grp = 2'd2; word = 2'd0; end
            5'd6:  begin grp = 2'd0; word = 2'd1; lane = 2'd3; end
            5'd7:  begin grp = 2'd1; word = 2'd1; lane = 2'd2; end
            5'd8:  begin grp = 2'd2; word = 2'd1; end
            5'd9:  begin grp = 2'd0; word = 2'd1; lane = 2'd1; end
            5'd10: begin grp = 2'd1; word = 2'd1; lane = 2'd0; end
            5'd11: begin grp = 2'd2; word = 2'd1; end
            5'd12: begin grp = 2'd0; word = 2'd2; lane = 2'd3; end
            5'd13: begin grp = 2'd1; word = 2'd2; lane = 2'd2; end
            5'd14: begin grp = 2'd2; word = 2'd2; end
            5'd15: begin grp = 2'd0; word = 2'd2; lane = 2'd1; end
            5'd16: begin grp = 2'd1; word = 2'd2; lane = 2'd0; end
            5'd17: begin grp = 2'd2; word = 2'd2; end
            default: begin grp = 2'd0; word = 2'd0; lane = 2'd3; end
        endcase
        last = (pos == 5'(smfd_pkg::FrameBytes - 1));
        co2_next = co2_reg;
        temp_next = temp_reg;
        hum_next = hum_reg;
        fail_next = fail_in;
        if (grp == 2'd2) begin
            if (crc_in != s_axis_tdata) begin
                fail_next = 1'b1;
            end
        end else begin
            case (word)
                2'd0: co2_next[lane*8 +: 8] = s_axis_tdata;
                2'd1: temp_next[lane*8 +: 8] = s_axis_tdata;
                default: hum_next[lane*8 +: 8] = s_axis_tdata;
            endcase
        end
        frame.co2_bits = co2_next;
        frame.temp_bits = temp_next;
        frame.hum_bits = hum_next;
        frame.crc_ok = !fail_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 5'd0;
            crc_reg <= smfd_pkg::CrcInit;
            fail_reg <= 1'b0;
            co2_reg <= 32'd0;
            temp_reg <= 32'd0;
            hum_reg <= 32'd0;
            low_reg <= smfd_pkg::Co2LowReset;
            high_reg <= smfd_pkg::Co2HighReset;
        end else begin
            if (cfg_wr_en && cfg_wr_index == smfd_pkg::RegCo2Low) begin
                low_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_wr_index == smfd_pkg::RegCo2High) begin
                high_reg <= cfg_wr_data;
            end
            if (fire) begin
                co2_reg <= co2_next;
                temp_reg <= temp_next;
                hum_reg <= hum_next;
                if (last) begin
                    pos_reg <= 5'd0;
                    crc_reg <= smfd_pkg::CrcInit;
                    fail_reg <= 1'b0;
                end else begin
                    pos_reg <= pos + 5'd1;
                    crc_reg <= (grp == 2'd2) ? smfd_pkg::CrcInit
                                             : smfd_pkg::crc_byte(crc_in, s_axis_tdata);
                    fail_reg <= fail_next;
                end
            end
        end
    end

    smfd_check u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .frame_valid   (fire && last),
        .frame         (frame),
        .co2_low_limit (low_reg),
        .co2_high_limit(high_reg),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_data      (full),
        .can_take      (s_axis_tready)
    );

    assign m_axis_tdata = full;

endmodule

@@ verif/tb_top.sv @@
module tb_top;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } rx_word_t;

    typedef struct packed {
        logic [15:0] co2_ppm;
        logic [31:0] temperature_bits;
        logic [31:0] humidity_bits;
        logic        crc_ok;
        logic        in_range;
    } reading_t;

    localparam int unsigned CycleLimit = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_index;
    logic [15:0] cfg_wr_data;

    rx_word_t    rx_pending[$];
    reading_t    readings_due[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stall_cycles;
    logic        stall_req = 1'b0;
    int unsigned cycle_count;
    int unsigned err_count;

    logic [15:0] lim_low;
    logic [15:0] lim_high;
    logic [4:0]  frame_pos = 5'd0;
    logic [7:0]  frame_crc = 8'hFF;
    logic        frame_bad = 1'b0;
    logic [31:0] co2_word = 32'd0;
    logic [31:0] temp_word = 32'd0;
    logic [31:0] hum_word = 32'd0;

    sensor_measurement_frame_decoder_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ 8'h31) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [32:0] float_order_key(input logic [31:0] f);
        logic [31:0] v;
        v = (f[30:0] == 31'd0) ? 32'd0 : f;
        return {1'b0, v[31] ? ~v : (v | 32'h8000_0000)};
    endfunction

    function automatic logic float_is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    function automatic logic float_not_above(input logic [31:0] a, input logic [31:0] b);
        if (float_is_nan(a) || float_is_nan(b)) begin
            return 1'b0;
        end
        return float_order_key(a) <= float_order_key(b);
    endfunction

    function automatic logic [15:0] float_to_ppm(input logic [31:0] f);
        int          ex;
        logic [23:0] mant;
        if (f[31] || float_is_nan(f) || f[30:23] < 8'd127) begin
            return 16'd0;
        end
        ex = int'(f[30:23]) - 127;
        if (ex >= 16) begin
            return 16'hFFFF;
        end
        mant = {1'b1, f[22:0]};
        return 16'(mant >> (23 - ex));
    endfunction

    function automatic logic [31:0] ppm_to_float(input logic [15:0] n);
        int msb;
        msb = 0;
        if (n == 16'd0) begin
            return 32'd0;
        end
        for (int k = 0; k < 16; k++) begin
            if (n[k]) begin
                msb = k;
            end
        end
        return {1'b0, 8'(127 + msb), 23'((32'(n) << (23 - msb)) & 32'h7F_FFFF)};
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic mark);
        int          grp_off;
        int          word_off;
        int          sh;
        reading_t    r;
        logic [31:0] msk;
        if (mark) begin
            frame_pos = 5'd0;
            frame_crc = 8'hFF;
            frame_bad = 1'b0;
        end
        if (frame_pos >= 5'd18) begin
            frame_pos = 5'd0;
        end
        grp_off = frame_pos % 3;
        word_off = frame_pos % 6;
        if (grp_off == 2) begin
            if (frame_crc != b) begin
                frame_bad = 1'b1;
            end
            frame_crc = 8'hFF;
        end else begin
            frame_crc = crc8_step(frame_crc, b);
            sh = (word_off < 3) ? 24 - 8 * word_off : 8 - 8 * (word_off - 3);
            msk = ~(32'hFF << sh);
            case (frame_pos / 6)
                0: co2_word = (co2_word & msk) | (32'(b) << sh);
                1: temp_word = (temp_word & msk) | (32'(b) << sh);
                default: hum_word = (hum_word & msk) | (32'(b) << sh);
            endcase
        end
        if (frame_pos != 5'd17) begin
            frame_pos = frame_pos + 5'd1;
            return;
        end
        r.co2_ppm = float_to_ppm(co2_word);
        r.temperature_bits = temp_word;
        r.humidity_bits = hum_word;
        r.crc_ok = !frame_bad;
        r.in_range = r.crc_ok && r.co2_ppm >= lim_low && r.co2_ppm <= lim_high
            && float_not_above(smfd_pkg::FltTempLow, temp_word)
            && float_not_above(temp_word, smfd_pkg::FltTempHigh)
            && float_not_above(32'd0, hum_word)
            && float_not_above(hum_word, smfd_pkg::FltHumHigh);
        readings_due.push_back(r);
        frame_pos = 5'd0;
        frame_crc = 8'hFF;
        frame_bad = 1'b0;
    endtask

    task automatic queue_frame(input logic [31:0] co2, input logic [31:0] t,
                               input logic [31:0] h, input logic [5:0] bad_crc,
                               input logic mark);
        logic [31:0] w;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  c;
        for (int g = 0; g < 6; g++) begin
            w = (g < 2) ? co2 : (g < 4) ? t : h;
            b0 = g[0] ? w[15:8] : w[31:24];
            b1 = g[0] ? w[7:0] : w[23:16];
            c = crc8_step(crc8_step(8'hFF, b0), b1);
            if (bad_crc[g]) begin
                c = c ^ 8'($urandom_range(1, 255));
            end
            rx_pending.push_back('{b0, (g == 0) && mark});
            rx_pending.push_back('{b1, 1'b0});
            rx_pending.push_back('{c, 1'b0});
        end
    endtask

    function automatic logic [31:0] plausible_float(input int lo_exp, input int hi_exp);
        return {1'($urandom_range(0, 3) == 0), 8'($urandom_range(lo_exp, hi_exp)),
                23'($urandom)};
    endfunction

    task automatic queue_random_frame();
        logic [31:0] co2;
        logic [31:0] t;
        logic [31:0] h;
        logic [5:0]  bad;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        co2 = (sel < 6) ? ppm_to_float(16'($urandom_range(0, 12000)))
            : (sel < 8) ? plausible_float(110, 150) : $urandom;
        t = ($urandom_range(0, 9) < 8) ? plausible_float(120, 133) : $urandom;
        h = ($urandom_range(0, 9) < 8) ? {1'b0, 8'($urandom_range(118, 134)), 23'($urandom)}
            : $urandom;
        bad = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'd0;
        queue_frame(co2, t, h, bad, $urandom_range(0, 1));
    endtask

    task automatic queue_noise(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            rx_pending.push_back('{8'($urandom), 1'($urandom_range(0, 5) == 0)});
        end
    endtask

    task automatic write_limit(input logic [1:0] idx, input logic [15:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= v;
        if (idx == smfd_pkg::RegCo2Low) begin
            lim_low = v;
        end else begin
            lim_high = v;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (rx_pending.size() != 0 || readings_due.size() != 0 || s_axis_tvalid) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'd0;
            s_axis_tuser <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= rx_pending[0].rx_byte;
                s_axis_tuser <= rx_pending[0].frame_start;
                void'(rx_pending.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_cycles <= 0;
        end else if (stall_req) begin
            stall_cycles <= 300;
        end else if (stall_cycles != 0) begin
            stall_cycles <= stall_cycles - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (stall_req || stall_cycles != 0) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            decode_byte(s_axis_tdata, s_axis_tuser);
        end
    end

    always @(posedge aclk) begin
        reading_t got;
        reading_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tdata[79:48],
                   m_axis_tdata[80], m_axis_tdata[81]};
            if (readings_due.size() == 0) begin
                err_count <= err_count + 1;
                if (err_count < 10) begin
                    $display("unexpected reading %h", got);
                end
            end else begin
                want = readings_due.pop_front();
                if (got !== want) begin
                    err_count <= err_count + 1;
                    if (err_count < 10) begin
                        $display("reading mismatch: expected %h %h %h %b %b, got %h %h %h %b %b",
                                 want.co2_ppm, want.temperature_bits, want.humidity_bits,
                                 want.crc_ok, want.in_range, got.co2_ppm,
                                 got.temperature_bits, got.humidity_bits, got.crc_ok,
                                 got.in_range);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = smfd_pkg::RegCo2Low;
        cfg_wr_data = 16'd0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        lim_low = smfd_pkg::Co2LowReset;
        lim_high = smfd_pkg::Co2HighReset;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        queue_frame(32'h43C8_0000, 32'hC120_0000, 32'h0000_0000, 6'd0, 1'b1);
        queue_frame(32'h461C_4000, 32'h4270_0000, 32'h42C8_0000, 6'd0, 1'b0);
        queue_frame(32'hC2C8_0000, 32'h8000_0000, 32'h7FC0_0000, 6'd0, 1'b1);
        queue_frame(32'h7FC0_0000, 32'h4270_0001, 32'h42C8_0001, 6'd0, 1'b0);
        queue_frame(32'h7F80_0000, 32'hC120_0001, 32'h8000_0001, 6'd0, 1'b1);
        queue_frame(32'h477F_FF00, 32'h41A0_0000, 32'h4248_0000, 6'd0, 1'b1);
        queue_frame(32'h4788_B800, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 1'b0);
        queue_frame(32'h4400_0000, 32'h41A0_0000, 32'h4248_0000, 6'b100001, 1'b1);
        rx_pending.push_back('{8'hFF, 1'b1});
        queue_noise(6);
        queue_frame(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 6'd0, 1'b1);
        drain();

        write_limit(smfd_pkg::RegCo2Low, 16'd0);
        write_limit(smfd_pkg::RegCo2High, 16'hFFFF);
        send_idle_pct = 22;
        recv_idle_pct = 85;
        for (int k = 0; k < 8; k++) begin
            queue_random_frame();
            if ($urandom_range(0, 4) == 0) begin
                queue_noise($urandom_range(1, 20));
            end
        end
        drain();

        write_limit(smfd_pkg::RegCo2Low, 16'hFFFF);
        write_limit(smfd_pkg::RegCo2High, 16'd0);
        send_idle_pct = 85;
        recv_idle_pct = 22;
        for (int k = 0; k < 4; k++) begin
            queue_random_frame();
        end
        drain();

        write_limit(smfd_pkg::RegCo2Low, 16'($urandom_range(0, 2000)));
        write_limit(smfd_pkg::RegCo2High, 16'($urandom_range(3000, 12000)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge aclk);
        stall_req <= 1'b1;
        @(posedge aclk);
        stall_req <= 1'b0;
        for (int k = 0; k < 6; k++) begin
            queue_random_frame();
            if ($urandom_range(0, 5) == 0) begin
                queue_noise($urandom_range(1, 10));
            end
        end
        drain();

        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
